>>> src/ilfl_pkg.sv
// Shared types and constants for the indexed list with free list.
package ilfl_pkg;

   localparam int NUM_SLOTS_DEF = 16;
   localparam int TAG_BITS_DEF  = 8;

   localparam int CMD_W    = 2;
   localparam int SLOT_W   = 4;
   localparam int TAG_W    = 8;
   localparam int STATUS_W = 2;

   localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_FIND   = 2'd2;

   localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADD_WR,
      ST_ADD_LINK,
      ST_WALK,
      ST_RM_FREE,
      ST_RESP
   } state_type;

endpackage

>>> src/ilfl_ifs.sv
// Request and response channel interfaces.
interface ilfl_req_if;
   logic                         valid;
   logic                         ready;
   logic [ilfl_pkg::CMD_W-1:0]   cmd;
   logic [ilfl_pkg::SLOT_W-1:0]  slot_in;
   logic [ilfl_pkg::TAG_W-1:0]   type_tag;

   modport source (output valid, output cmd, output slot_in, output type_tag, input ready);
   modport sink   (input valid, input cmd, input slot_in, input type_tag, output ready);
endinterface

interface ilfl_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [ilfl_pkg::STATUS_W-1:0] status;
   logic [ilfl_pkg::SLOT_W-1:0]   slot_out;

   modport source (output valid, output status, output slot_out, input ready);
   modport sink   (input valid, input status, input slot_out, output ready);
endinterface

>>> src/indexed_list_with_free_list_unit.sv
// Slot pool with an in-use linked list and a free list, walked one slot per cycle.
// Steps from request accept to response word registered: add pops the free head (ADD_WR)
// and links it behind the tail (ADD_LINK) unless the list was empty; add when full and unused
// commands go to RESP; remove and find walk at most NUM_SLOTS slots (WALK); a remove hit then
// frees it (RM_FREE). RESP waits while the response word is still held; one request at a time.
// Reset clears control state; untouched link entries read via a fill count, no clear pass.
module indexed_list_with_free_list_unit #(
   parameter int NUM_SLOTS = ilfl_pkg::NUM_SLOTS_DEF,
   parameter int TAG_BITS  = ilfl_pkg::TAG_BITS_DEF
) (
   input  logic  clock,
   input  logic  reset,
   ilfl_req_if.sink   req_ch,
   ilfl_rsp_if.source rsp_ch
);

   localparam int LINK_W = $clog2(NUM_SLOTS + 1);
   localparam int IDX_W  = $clog2(NUM_SLOTS);
   localparam logic [LINK_W-1:0] NIL = LINK_W'(NUM_SLOTS);

   // link and tag stores
   logic [LINK_W-1:0]   link_mem [NUM_SLOTS];
   logic [TAG_BITS-1:0] tag_mem  [NUM_SLOTS];

   ilfl_pkg::state_type state_ff, state_in;

   logic [LINK_W-1:0] list_head_ff, list_head_in;
   logic [LINK_W-1:0] list_tail_ff, list_tail_in;
   logic [LINK_W-1:0] free_head_ff, free_head_in;
   logic [LINK_W-1:0] fill_ff, fill_in;
   logic [LINK_W-1:0] cur_ff, cur_in;
   logic [LINK_W-1:0] prev_ff, prev_in;
   logic [LINK_W-1:0] n_ff, n_in;
   logic [ilfl_pkg::CMD_W-1:0]  cmd_ff, cmd_in;
   logic [ilfl_pkg::SLOT_W-1:0] tgt_ff, tgt_in;
   logic [TAG_BITS-1:0]         tag_ff, tag_in;
   logic [ilfl_pkg::STATUS_W-1:0] res_status_ff, res_status_in;
   logic [ilfl_pkg::SLOT_W-1:0]   res_slot_ff, res_slot_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [ilfl_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [ilfl_pkg::SLOT_W-1:0]   rsp_slot_ff, rsp_slot_in;

   // read port
   logic [LINK_W-1:0]   rd_addr;
   logic [LINK_W-1:0]   link_q_ff;
   logic [TAG_BITS-1:0] tag_q_ff;
   logic                rd_fresh_ff;
   logic [LINK_W-1:0]   rd_plus_ff;
   logic [LINK_W-1:0]   vlink;

   // write ports
   logic                link_we;
   logic [LINK_W-1:0]   link_wa;
   logic [LINK_W-1:0]   link_wd;
   logic                tag_we;

   logic [TAG_BITS+ilfl_pkg::TAG_W-1:0]  req_tag_wide;
   logic [ilfl_pkg::SLOT_W+LINK_W-1:0]   cur_wide;
   logic [ilfl_pkg::SLOT_W+LINK_W-1:0]   tgt_wide;
   logic [ilfl_pkg::SLOT_W-1:0]          cur_slot;

   logic accept, out_free;
   logic pool_empty, list_empty, walk_end, rm_hit, find_hit, add_is_cmd;

   assign accept   = req_ch.valid && req_ch.ready;
   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   assign req_ch.ready    = (state_ff == ilfl_pkg::ST_IDLE);
   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.status   = rsp_status_ff;
   assign rsp_ch.slot_out = rsp_slot_ff;

   // slots at or above the fill count were never touched and still link to i+1
   assign vlink = rd_fresh_ff ? rd_plus_ff : link_q_ff;

   assign req_tag_wide = {{TAG_BITS{1'b0}}, req_ch.type_tag};
   assign cur_wide     = {{ilfl_pkg::SLOT_W{1'b0}}, cur_ff};
   assign tgt_wide     = {{LINK_W{1'b0}}, tgt_ff};
   assign cur_slot     = cur_wide[ilfl_pkg::SLOT_W-1:0];

   assign add_is_cmd = (req_ch.cmd == ilfl_pkg::CMD_ADD);
   assign pool_empty = (free_head_ff >= NIL);
   assign list_empty = (list_head_ff >= NIL) || (list_tail_ff >= NIL);
   assign walk_end   = (cur_ff >= NIL) || (n_ff == NIL);
   assign rm_hit     = (cmd_ff == ilfl_pkg::CMD_REMOVE) && (cur_wide == tgt_wide);
   assign find_hit   = (cmd_ff == ilfl_pkg::CMD_FIND) && (tag_q_ff == tag_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ilfl_pkg::ST_IDLE: begin
            if (accept) begin
               if (add_is_cmd) begin
                  state_in = pool_empty ? ilfl_pkg::ST_RESP : ilfl_pkg::ST_ADD_WR;
               end else if (req_ch.cmd == ilfl_pkg::CMD_REMOVE ||
                            req_ch.cmd == ilfl_pkg::CMD_FIND) begin
                  state_in = ilfl_pkg::ST_WALK;
               end else begin
                  state_in = ilfl_pkg::ST_RESP;
               end
            end
         end
         ilfl_pkg::ST_ADD_WR: begin
            state_in = list_empty ? ilfl_pkg::ST_RESP : ilfl_pkg::ST_ADD_LINK;
         end
         ilfl_pkg::ST_ADD_LINK: state_in = ilfl_pkg::ST_RESP;
         ilfl_pkg::ST_WALK: begin
            if (walk_end || find_hit) begin
               state_in = ilfl_pkg::ST_RESP;
            end else if (rm_hit) begin
               state_in = ilfl_pkg::ST_RM_FREE;
            end
         end
         ilfl_pkg::ST_RM_FREE: state_in = ilfl_pkg::ST_RESP;
         ilfl_pkg::ST_RESP: begin
            if (out_free) begin
               state_in = ilfl_pkg::ST_IDLE;
            end
         end
         default: state_in = ilfl_pkg::ST_IDLE;
      endcase
   end

   // datapath and memory controls
   always_comb begin
      list_head_in  = list_head_ff;
      list_tail_in  = list_tail_ff;
      free_head_in  = free_head_ff;
      fill_in       = fill_ff;
      cur_in        = cur_ff;
      prev_in       = prev_ff;
      n_in          = n_ff;
      cmd_in        = cmd_ff;
      tgt_in        = tgt_ff;
      tag_in        = tag_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rd_addr       = cur_ff;
      link_we       = 1'b0;
      link_wa       = cur_ff;
      link_wd       = NIL;
      tag_we        = 1'b0;
      case (state_ff)
         ilfl_pkg::ST_IDLE: begin
            rd_addr = add_is_cmd ? free_head_ff : list_head_ff;
            if (accept) begin
               cmd_in        = req_ch.cmd;
               tgt_in        = req_ch.slot_in;
               tag_in        = req_tag_wide[TAG_BITS-1:0];
               cur_in        = list_head_ff;
               prev_in       = NIL;
               n_in          = '0;
               res_status_in = add_is_cmd ? ilfl_pkg::STAT_FULL : ilfl_pkg::STAT_NOT_FOUND;
               res_slot_in   = '0;
            end
         end
         ilfl_pkg::ST_ADD_WR: begin
            // pop free head, tag it and terminate it
            free_head_in  = vlink;
            link_we       = 1'b1;
            link_wa       = free_head_ff;
            link_wd       = NIL;
            tag_we        = 1'b1;
            cur_in        = free_head_ff;
            res_status_in = ilfl_pkg::STAT_OK;
            res_slot_in   = ilfl_pkg::SLOT_W'({{ilfl_pkg::SLOT_W{1'b0}}, free_head_ff});
            if (free_head_ff == fill_ff) begin
               fill_in = fill_ff + LINK_W'(1);
            end
            if (list_empty) begin
               list_head_in = free_head_ff;
               list_tail_in = free_head_ff;
            end
         end
         ilfl_pkg::ST_ADD_LINK: begin
            link_we      = 1'b1;
            link_wa      = list_tail_ff;
            link_wd      = cur_ff;
            list_tail_in = cur_ff;
         end
         ilfl_pkg::ST_WALK: begin
            rd_addr = vlink;
            if (walk_end) begin
               res_status_in = ilfl_pkg::STAT_NOT_FOUND;
               res_slot_in   = '0;
            end else if (rm_hit) begin
               if (prev_ff >= NIL) begin
                  list_head_in = vlink;
               end else begin
                  link_we = 1'b1;
                  link_wa = prev_ff;
                  link_wd = vlink;
               end
               if (list_tail_ff == cur_ff) begin
                  list_tail_in = prev_ff;
               end
            end else if (find_hit) begin
               res_status_in = ilfl_pkg::STAT_OK;
               res_slot_in   = cur_slot;
            end else begin
               prev_in = cur_ff;
               cur_in  = vlink;
               n_in    = n_ff + LINK_W'(1);
            end
         end
         ilfl_pkg::ST_RM_FREE: begin
            // push removed slot onto the free list
            link_we       = 1'b1;
            link_wa       = cur_ff;
            link_wd       = free_head_ff;
            free_head_in  = cur_ff;
            res_status_in = ilfl_pkg::STAT_OK;
            res_slot_in   = cur_slot;
         end
         ilfl_pkg::ST_RESP: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_slot_in   = res_slot_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ilfl_pkg::ST_IDLE;
         list_head_ff <= NIL;
         list_tail_ff <= NIL;
         free_head_ff <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         list_head_ff <= list_head_in;
         list_tail_ff <= list_tail_in;
         free_head_ff <= free_head_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff        <= cur_in;
      prev_ff       <= prev_in;
      n_ff          <= n_in;
      cmd_ff        <= cmd_in;
      tgt_ff        <= tgt_in;
      tag_ff        <= tag_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
   end

   // memories: one write and one registered read each per cycle
   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[link_wa[IDX_W-1:0]] <= link_wd;
      end
      if (tag_we) begin
         tag_mem[free_head_ff[IDX_W-1:0]] <= tag_ff;
      end
      link_q_ff   <= link_mem[rd_addr[IDX_W-1:0]];
      tag_q_ff    <= tag_mem[rd_addr[IDX_W-1:0]];
      rd_fresh_ff <= (rd_addr >= fill_ff);
      rd_plus_ff  <= rd_addr + LINK_W'(1);
   end

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= NIL)
      else $error("fill count beyond pool size");

   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      n_ff <= NIL || state_ff != ilfl_pkg::ST_WALK)
      else $error("walk ran past pool size");

   a_empty_pool_all_used: assert property (@(posedge clock) disable iff (reset)
      (free_head_ff >= NIL) |-> (fill_ff == NIL))
      else $error("free list empty with untouched slots left");

   a_head_tail_nil: assert property (@(posedge clock) disable iff (reset)
      (list_head_ff >= NIL) == (list_tail_ff >= NIL))
      else $error("list head and tail disagree on empty");

   a_resp_load: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ilfl_pkg::ST_RESP && out_free) |=>
         (rsp_valid_ff && state_ff == ilfl_pkg::ST_IDLE))
      else $error("response word not loaded");

   a_fail_slot_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != ilfl_pkg::STAT_OK) |-> (rsp_slot_ff == '0))
      else $error("failed response carries a slot");

endmodule
